// ===== hdl/qbse_pkg.sv =====
package qbse_pkg;

  localparam int MAX_POINTS = 256;
  localparam int MAX_DIM    = 4;
  localparam int MIN_POINTS = 3;

  localparam int WORD_W    = 32;
  localparam int PT_W      = 8;
  localparam int COMP_W    = 2;
  localparam int CNT_W     = 9;
  localparam int DIM_W     = 3;
  localparam int T_W       = 17;
  localparam int FRAC_W    = 16;
  localparam int SEGP_W    = T_W + CNT_W;
  localparam int SEG_W     = SEGP_W - FRAC_W;
  localparam int P_W       = WORD_W + 3;
  localparam int MULY_W    = T_W + 1;
  localparam int ACC_W     = P_W + MULY_W;
  localparam int MEM_DEPTH = MAX_POINTS * MAX_DIM;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  localparam logic [T_W-1:0] T_ONE = T_W'(65536);

  localparam logic signed [ACC_W-1:0] HALF_Q16 = ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] HALF_Q17 = ACC_W'(65536);

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_POS   = 2'd1;
  localparam logic [1:0] REQ_VEL   = 2'd2;
  localparam logic [1:0] REQ_ACC   = 2'd3;

  localparam logic [1:0] REG_CLOSED = 2'd0;
  localparam logic [1:0] REG_COUNT  = 2'd1;
  localparam logic [1:0] REG_DIM    = 2'd2;

  localparam logic [3:0] POS_LAST_STEP = 4'd8;
  localparam logic [3:0] VEL_LAST_STEP = 4'd3;
  localparam logic [3:0] ACC_LAST_STEP = 4'd0;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_SEG  = 8'b0000_0100,
    S_IDX  = 8'b0000_1000,
    S_RD   = 8'b0001_0000,
    S_BLD  = 8'b0010_0000,
    S_MAC  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  function automatic logic [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] x);
    logic fits;
    fits = (&x[ACC_W-1:WORD_W-1]) || !(|x[ACC_W-1:WORD_W-1]);
    if (fits) begin
      sat_word = x[WORD_W-1:0];
    end else if (x[ACC_W-1]) begin
      sat_word = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      sat_word = {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== hdl/qbse_ram.sv =====
module qbse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/quadratic_bspline_evaluator_core.sv =====
// Quadratic B-spline evaluator, Q16.16. Control-point components live in a 1024-word
// single-port-read memory that holds garbage until written; there is no clearing pass.
// A write request (tuser 0) returns nothing. An evaluation runs the setup states S_MUL,
// S_SEG and S_IDX, then per component the memory reads (S_RD), a build state (S_BLD), a
// multiply sequence (S_MAC) on the one shared 35x18 multiplier for position and first
// derivative (second derivative is formed without it), and S_OUT, which hands the
// result to the output register once that register is free. The next item is taken
// once the last result of the evaluation sits in the output register. With fewer
// than 3 points an evaluation returns a single status result.
module quadratic_bspline_evaluator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // point_index[7:0], component[9:8], value[41:10], param_t[58:42], want_components[61:59]
  input  logic [qbse_pkg::IN_TDATA_W-1:0]     in_tdata,
  // req_type[1:0]
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // result_value[31:0], result_component[33:32]
  output logic [qbse_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast,
  // status[0]
  output logic [0:0]                          out_tuser,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [qbse_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [qbse_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [qbse_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                                cfg_pready
);

  // configuration
  logic                          cfg_wr;
  logic [1:0]                    cfg_idx;
  logic                          closed_r;
  logic [qbse_pkg::CNT_W-1:0]    count_r;
  logic [qbse_pkg::DIM_W-1:0]    dim_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_r <= 1'b0;
      count_r  <= '0;
      dim_r    <= qbse_pkg::DIM_W'(3);
    end else if (cfg_wr) begin
      case (cfg_idx)
        qbse_pkg::REG_CLOSED: closed_r <= cfg_pwdata[0];
        qbse_pkg::REG_COUNT:  count_r  <= cfg_pwdata[qbse_pkg::CNT_W-1:0];
        qbse_pkg::REG_DIM:    dim_r    <= cfg_pwdata[qbse_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      qbse_pkg::REG_CLOSED: cfg_prdata = qbse_pkg::CFG_DW'(closed_r);
      qbse_pkg::REG_COUNT:  cfg_prdata = qbse_pkg::CFG_DW'(count_r);
      qbse_pkg::REG_DIM:    cfg_prdata = qbse_pkg::CFG_DW'(dim_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // effective configuration
  logic [qbse_pkg::CNT_W-1:0] cnt_eff;
  logic [qbse_pkg::CNT_W-1:0] segs;
  logic [qbse_pkg::DIM_W-1:0] dim_eff;
  logic                       few_points;

  always_comb begin
    cnt_eff = (count_r > qbse_pkg::CNT_W'(qbse_pkg::MAX_POINTS)) ?
              qbse_pkg::CNT_W'(qbse_pkg::MAX_POINTS) : count_r;
    segs    = closed_r ? cnt_eff : cnt_eff - qbse_pkg::CNT_W'(2);
    if (dim_r == '0) begin
      dim_eff = qbse_pkg::DIM_W'(1);
    end else if (dim_r > qbse_pkg::DIM_W'(qbse_pkg::MAX_DIM)) begin
      dim_eff = qbse_pkg::DIM_W'(qbse_pkg::MAX_DIM);
    end else begin
      dim_eff = dim_r;
    end
    few_points = cnt_eff < qbse_pkg::CNT_W'(qbse_pkg::MIN_POINTS);
  end

  // input fields
  logic                                in_fire;
  logic [qbse_pkg::PT_W-1:0]           in_point;
  logic [qbse_pkg::COMP_W-1:0]         in_comp;
  logic [qbse_pkg::WORD_W-1:0]         in_value;
  logic [qbse_pkg::T_W-1:0]            in_t;
  logic [qbse_pkg::DIM_W-1:0]          in_want;
  logic [qbse_pkg::T_W-1:0]            t_clamp;
  logic [qbse_pkg::DIM_W-1:0]          want_eff;
  logic [qbse_pkg::DIM_W-1:0]          nres;

  assign in_point = in_tdata[7:0];
  assign in_comp  = in_tdata[9:8];
  assign in_value = in_tdata[41:10];
  assign in_t     = in_tdata[58:42];
  assign in_want  = in_tdata[61:59];

  always_comb begin
    t_clamp  = (in_t > qbse_pkg::T_ONE) ? qbse_pkg::T_ONE : in_t;
    want_eff = (in_want == '0) ? qbse_pkg::DIM_W'(1) : in_want;
    nres     = (want_eff < dim_eff) ? want_eff : dim_eff;
  end

  // control state
  qbse_pkg::state_t             state_r, state_nxt;
  logic [1:0]                   rstep_r, rstep_nxt;
  logic [3:0]                   mstep_r, mstep_nxt;
  logic [qbse_pkg::COMP_W-1:0]  comp_r, comp_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_load;
  logic                         mac_done;

  // datapath registers
  logic [1:0]                          req_r;
  logic [qbse_pkg::T_W-1:0]            t_r;
  logic [qbse_pkg::COMP_W-1:0]         nres_last_r;
  logic                                stat_r;
  logic [qbse_pkg::SEGP_W-1:0]         prod_seg_r;
  logic [qbse_pkg::PT_W-1:0]           seg_r;
  logic [qbse_pkg::T_W-1:0]            u_r;
  logic [qbse_pkg::T_W-1:0]            ul_r;
  logic [qbse_pkg::PT_W-1:0]           i0_r, i1_r, i2_r;
  logic                                first_r, lastseg_r;
  logic signed [qbse_pkg::WORD_W-1:0]  w0_r, w1_r, w2_r;
  logic signed [qbse_pkg::P_W-1:0]     p0_r, p1_r, p2_r, d0_r, d1_r, a_r, b_r;
  logic signed [qbse_pkg::ACC_W-1:0]   prod_r, acc_r;
  logic [qbse_pkg::WORD_W-1:0]         res_r;
  logic [qbse_pkg::OUT_TDATA_W-1:0]    out_tdata_r;
  logic                                out_last_r;
  logic                                out_stat_r;

  assign in_tready = (state_r == qbse_pkg::S_IDLE);
  assign in_fire   = in_tvalid & in_tready;

  always_comb begin
    case (req_r)
      qbse_pkg::REQ_POS: mac_done = (mstep_r == qbse_pkg::POS_LAST_STEP);
      qbse_pkg::REQ_VEL: mac_done = (mstep_r == qbse_pkg::VEL_LAST_STEP);
      default:           mac_done = (mstep_r == qbse_pkg::ACC_LAST_STEP);
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    rstep_nxt     = rstep_r;
    mstep_nxt     = mstep_r;
    comp_nxt      = comp_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_load      = 1'b0;
    case (state_r)
      qbse_pkg::S_IDLE: begin
        if (in_fire && in_tuser != qbse_pkg::REQ_WRITE) begin
          comp_nxt  = '0;
          state_nxt = few_points ? qbse_pkg::S_OUT : qbse_pkg::S_MUL;
        end
      end
      qbse_pkg::S_MUL: state_nxt = qbse_pkg::S_SEG;
      qbse_pkg::S_SEG: state_nxt = qbse_pkg::S_IDX;
      qbse_pkg::S_IDX: begin
        rstep_nxt = '0;
        state_nxt = qbse_pkg::S_RD;
      end
      qbse_pkg::S_RD: begin
        rstep_nxt = rstep_r + 2'd1;
        if (rstep_r == 2'd3) begin
          state_nxt = qbse_pkg::S_BLD;
        end
      end
      qbse_pkg::S_BLD: begin
        mstep_nxt = '0;
        state_nxt = qbse_pkg::S_MAC;
      end
      qbse_pkg::S_MAC: begin
        mstep_nxt = mstep_r + 4'd1;
        if (mac_done) begin
          state_nxt = qbse_pkg::S_OUT;
        end
      end
      qbse_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          if (comp_r == nres_last_r) begin
            state_nxt = qbse_pkg::S_IDLE;
          end else begin
            comp_nxt  = comp_r + qbse_pkg::COMP_W'(1);
            rstep_nxt = '0;
            state_nxt = qbse_pkg::S_RD;
          end
        end
      end
      default: state_nxt = qbse_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qbse_pkg::S_IDLE;
      rstep_r     <= '0;
      mstep_r     <= '0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rstep_r     <= rstep_nxt;
      mstep_r     <= mstep_nxt;
      comp_r      <= comp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // control-point memory
  logic                              ram_we;
  logic [qbse_pkg::MEM_AW-1:0]       ram_waddr;
  logic [qbse_pkg::MEM_AW-1:0]       ram_raddr;
  logic [qbse_pkg::WORD_W-1:0]       ram_rdata;
  logic [qbse_pkg::PT_W-1:0]         rd_point;

  assign ram_we    = in_fire && (in_tuser == qbse_pkg::REQ_WRITE);
  assign ram_waddr = {in_point, in_comp};

  always_comb begin
    case (rstep_r)
      2'd0:    rd_point = i0_r;
      2'd1:    rd_point = i1_r;
      default: rd_point = i2_r;
    endcase
  end

  assign ram_raddr = {rd_point, comp_r};

  qbse_ram #(
    .WIDTH (qbse_pkg::WORD_W),
    .DEPTH (qbse_pkg::MEM_DEPTH)
  ) u_points (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_value),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // segment, local parameter and point indexes
  logic [qbse_pkg::SEGP_W-1:0]   prod_seg;
  logic [qbse_pkg::SEG_W-1:0]    seg_raw;
  logic [qbse_pkg::CNT_W-1:0]    seg_c;
  logic [qbse_pkg::SEGP_W-1:0]   u_full;
  logic [qbse_pkg::CNT_W-1:0]    s1, i1n, s2, i2n;

  assign prod_seg = qbse_pkg::SEGP_W'(t_r) * qbse_pkg::SEGP_W'(segs);

  always_comb begin
    seg_raw = prod_seg_r[qbse_pkg::SEGP_W-1:qbse_pkg::FRAC_W];
    seg_c   = (seg_raw >= qbse_pkg::SEG_W'(segs)) ? segs - qbse_pkg::CNT_W'(1) :
              seg_raw[qbse_pkg::CNT_W-1:0];
    u_full  = prod_seg_r - {seg_c, {qbse_pkg::FRAC_W{1'b0}}};
    s1      = qbse_pkg::CNT_W'(seg_r) + qbse_pkg::CNT_W'(1);
    i1n     = (s1 >= cnt_eff) ? s1 - cnt_eff : s1;
    s2      = i1n + qbse_pkg::CNT_W'(1);
    i2n     = (s2 >= cnt_eff) ? s2 - cnt_eff : s2;
  end

  // Bezier points, doubled
  logic signed [qbse_pkg::P_W-1:0] w0e, w1e, w2e, p0n, p1n, p2n;

  always_comb begin
    w0e = qbse_pkg::P_W'(w0_r);
    w1e = qbse_pkg::P_W'(w1_r);
    w2e = qbse_pkg::P_W'(w2_r);
    p0n = first_r ? (w0e <<< 1) : w0e + w1e;
    p1n = w1e <<< 1;
    p2n = lastseg_r ? (w2e <<< 1) : w1e + w2e;
  end

  // multiply sequence
  logic signed [qbse_pkg::P_W-1:0]    mul_x;
  logic                               mul_y_ul;
  logic signed [qbse_pkg::MULY_W-1:0] mul_y;
  logic signed [qbse_pkg::ACC_W-1:0]  mul_p;
  qbse_pkg::acc_op_t                  acc_op;
  logic                               lat_a, lat_b;
  logic signed [qbse_pkg::ACC_W-1:0]  rnd16, rnd17, acc2;

  always_comb begin
    mul_x    = '0;
    mul_y_ul = 1'b1;
    acc_op   = qbse_pkg::ACC_HOLD;
    lat_a    = 1'b0;
    lat_b    = 1'b0;
    case (req_r)
      qbse_pkg::REQ_POS: begin
        case (mstep_r)
          4'd0: mul_x = p0_r;
          4'd1: begin
            mul_x = p1_r; mul_y_ul = 1'b0; acc_op = qbse_pkg::ACC_LOAD;
          end
          4'd2: begin
            mul_x = p1_r; acc_op = qbse_pkg::ACC_ADD;
          end
          4'd3: begin
            mul_x = p2_r; mul_y_ul = 1'b0; acc_op = qbse_pkg::ACC_LOAD; lat_a = 1'b1;
          end
          4'd4: begin
            mul_x = a_r; acc_op = qbse_pkg::ACC_ADD;
          end
          4'd5: begin
            acc_op = qbse_pkg::ACC_LOAD; lat_b = 1'b1;
          end
          4'd6: begin
            mul_x = b_r; mul_y_ul = 1'b0;
          end
          4'd7: acc_op = qbse_pkg::ACC_ADD;
          default: ;
        endcase
      end
      qbse_pkg::REQ_VEL: begin
        case (mstep_r)
          4'd0: mul_x = d0_r;
          4'd1: begin
            mul_x = d1_r; mul_y_ul = 1'b0; acc_op = qbse_pkg::ACC_LOAD;
          end
          4'd2: acc_op = qbse_pkg::ACC_ADD;
          default: ;
        endcase
      end
      default: ;
    endcase
    mul_y = mul_y_ul ? qbse_pkg::MULY_W'(ul_r) : qbse_pkg::MULY_W'(u_r);
    mul_p = qbse_pkg::ACC_W'(mul_x) * qbse_pkg::ACC_W'(mul_y);
    rnd16 = (acc_r + qbse_pkg::HALF_Q16) >>> qbse_pkg::FRAC_W;
    rnd17 = (acc_r + qbse_pkg::HALF_Q17) >>> (qbse_pkg::FRAC_W + 1);
    acc2  = qbse_pkg::ACC_W'(p0_r) + qbse_pkg::ACC_W'(p2_r) - (qbse_pkg::ACC_W'(p1_r) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r       <= in_tuser;
      t_r         <= t_clamp;
      nres_last_r <= few_points ? '0 : qbse_pkg::COMP_W'(nres - qbse_pkg::DIM_W'(1));
      stat_r      <= few_points;
      res_r       <= '0;
    end
    if (state_r == qbse_pkg::S_MUL) begin
      prod_seg_r <= prod_seg;
    end
    if (state_r == qbse_pkg::S_SEG) begin
      seg_r <= seg_c[qbse_pkg::PT_W-1:0];
      u_r   <= u_full[qbse_pkg::T_W-1:0];
    end
    if (state_r == qbse_pkg::S_IDX) begin
      ul_r      <= qbse_pkg::T_ONE - u_r;
      i0_r      <= seg_r;
      i1_r      <= i1n[qbse_pkg::PT_W-1:0];
      i2_r      <= i2n[qbse_pkg::PT_W-1:0];
      first_r   <= !closed_r && (seg_r == '0);
      lastseg_r <= !closed_r && (qbse_pkg::CNT_W'(seg_r) == segs - qbse_pkg::CNT_W'(1));
    end
    if (state_r == qbse_pkg::S_RD) begin
      case (rstep_r)
        2'd1:    w0_r <= ram_rdata;
        2'd2:    w1_r <= ram_rdata;
        2'd3:    w2_r <= ram_rdata;
        default: ;
      endcase
    end
    if (state_r == qbse_pkg::S_BLD) begin
      p0_r <= p0n;
      p1_r <= p1n;
      p2_r <= p2n;
      d0_r <= p1n - p0n;
      d1_r <= p2n - p1n;
    end
    if (state_r == qbse_pkg::S_MAC) begin
      prod_r <= mul_p;
      case (acc_op)
        qbse_pkg::ACC_LOAD: acc_r <= prod_r;
        qbse_pkg::ACC_ADD:  acc_r <= acc_r + prod_r;
        default: ;
      endcase
      if (lat_a) begin
        a_r <= rnd16[qbse_pkg::P_W-1:0];
      end
      if (lat_b) begin
        b_r <= rnd16[qbse_pkg::P_W-1:0];
      end
      if (mac_done) begin
        case (req_r)
          qbse_pkg::REQ_POS: res_r <= qbse_pkg::sat_word(rnd17);
          qbse_pkg::REQ_VEL: res_r <= qbse_pkg::sat_word(rnd16);
          default:           res_r <= qbse_pkg::sat_word(acc2);
        endcase
      end
    end
    if (out_load) begin
      out_tdata_r <= qbse_pkg::OUT_TDATA_W'({comp_r, res_r});
      out_last_r  <= (comp_r == nres_last_r);
      out_stat_r  <= stat_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_stat_r;

endmodule

// ===== hdl/qbse_checker.sv =====
module qbse_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [1:0]                       in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [qbse_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast,
  input logic [0:0]                       out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == qbse_pkg::REQ_WRITE && !out_tvalid |=> !out_tvalid)
    else $error("write transfer produced a result");

  a_busy_midrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken while an evaluation is still running");

  a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && out_tdata == '0)
    else $error("status result is not a single zero result");

endmodule

bind quadratic_bspline_evaluator_core qbse_checker u_qbse_checker (.*);
